>>> rtl/bitmap_priority_task_scheduler_defines.svh
// Assertion macros for the bitmap priority task scheduler.
// Used by the checker module; depends on nothing else.
`ifndef BITMAP_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define BITMAP_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
// Clocked assertion, disabled while the active-low reset is low.
`define BPTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is also checked during reset.
`define BPTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/bpts_pkg.sv
// Package for the bitmap priority task scheduler.
// Holds item kinds, error codes, state encodings and helpers; no dependencies.
`default_nettype none
package bpts_pkg;
    localparam int unsigned PRIO_BITS = 6;
    localparam int unsigned NUM_PRIO = 64;
    localparam logic [PRIO_BITS-1:0] IDLE_PRIO = 6'd63;
    localparam int unsigned SUSPEND_BIT = 3;

    typedef enum logic [2:0] {
        K_TICK = 3'd0,
        K_CREATE = 3'd1,
        K_SCHED = 3'd2,
        K_START = 3'd3,
        K_WAIT = 3'd4,
        K_READY = 3'd5,
        K_REMOVE = 3'd6,
        K_CLEAR = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        E_OK = 2'd0,
        E_NO_SLOT = 2'd1,
        E_NO_WAITER = 2'd2,
        E_PRIO_USED = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_TICK_RD,
        S_TICK_WR,
        S_OUT
    } t_state;

    function automatic logic [PRIO_BITS:0] lowest_bit(input logic [NUM_PRIO-1:0] map);
        logic [PRIO_BITS:0] r;
        r = '0;
        for (int i = NUM_PRIO - 1; i >= 0; i--) begin
            if (map[i]) begin
                r = {1'b1, 6'(i)};
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/bpts_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read; no dependencies.
`default_nettype none
module bpts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/bitmap_priority_task_scheduler.sv
// A tick walks all 64 task memory entries when running and goes straight to the result when not;
// a ready-waiter item that finds a waiter adds a task memory write state before the result.
// One item at a time: the next input beat is taken once the result beat is gone.
// The tick walk reads and then rewrites each task memory entry in turn (S_TICK_RD, S_TICK_WR).
// Reset clears the ready map, presence bits, counters and current priority at once.
// Task and event memories hold no reset; their entries are defined once written.
`default_nettype none
module bitmap_priority_task_scheduler #(
    parameter int unsigned EVENTS = 256,
    parameter int unsigned TASK_SLOTS = 32,
    parameter int unsigned DELAY_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tuser: kind[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // tdata: task_prio[5:0], event_index[13:6], clear_mask[21:14],
    // wait_timeout[37:22], wait_status[45:38], sched_blocked[46], zero fill
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: result_prio[5:0], switch_needed[6], error_code[8:7],
    // switch_count[40:9], tick_count[72:41], zero fill
    output logic [79:0]      m_axis_tdata
);
    localparam int unsigned EV_AW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int unsigned TW = DELAY_BITS + 16;
    localparam int unsigned SLOT_W = $clog2(TASK_SLOTS + 1);

    bpts_pkg::t_state r_state, n_state;
    logic [2:0]  r_kind;
    logic [5:0]  r_prio;
    logic [7:0]  r_ev, r_cmask, r_wstat;
    logic [15:0] r_tmo;
    logic        r_blk;
    logic [63:0] r_ready, n_ready;
    logic [5:0]  r_cur, n_cur;
    logic        r_run, n_run;
    logic [63:0] r_present, n_present;
    logic [SLOT_W-1:0] r_free, n_free;
    logic [31:0] r_ticks, n_ticks, r_sw, n_sw;
    logic [5:0]  r_res, n_res;
    logic        r_swn, n_swn;
    logic [1:0]  r_err, n_err;
    logic [6:0]  r_idx, n_idx;
    logic        r_ovalid, n_ovalid;

    logic          t_we;
    logic [5:0]    t_waddr, t_raddr;
    logic [TW-1:0] t_wdata, t_rdata;
    logic          e_we;
    logic [EV_AW-1:0] e_addr;
    logic [63:0]   e_wdata, e_rdata;
    logic          ev_ok;
    logic [6:0]    low_r, low_e;
    logic [DELAY_BITS-1:0] d_rd, d_dec;
    logic [7:0]    st_rd, st_new;

    assign ev_ok = ({24'd0, r_ev} < 32'(EVENTS));
    assign e_addr = EV_AW'(r_ev);
    assign low_r = bpts_pkg::lowest_bit(r_ready);
    assign low_e = bpts_pkg::lowest_bit(e_rdata);
    assign d_rd = t_rdata[DELAY_BITS-1:0];
    assign st_rd = t_rdata[DELAY_BITS+7:DELAY_BITS];
    assign d_dec = d_rd - 1'b1;
    assign st_new = st_rd & ~r_cmask;

    bpts_ram #(.WIDTH(TW), .DEPTH(64)) u_task (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );
    bpts_ram #(.WIDTH(64), .DEPTH(EVENTS)) u_event (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_addr), .i_wdata(e_wdata),
        .i_raddr(e_addr), .o_rdata(e_rdata)
    );

    assign s_axis_tready = (r_state == bpts_pkg::S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, r_ticks, r_sw, r_err, r_swn, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpts_pkg::S_IDLE;
            r_ready <= '0;
            r_cur <= '0;
            r_run <= 1'b0;
            r_present <= '0;
            r_free <= SLOT_W'(TASK_SLOTS);
            r_ticks <= '0;
            r_sw <= '0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_cur <= n_cur;
            r_run <= n_run;
            r_present <= n_present;
            r_free <= n_free;
            r_ticks <= n_ticks;
            r_sw <= n_sw;
            r_ovalid <= n_ovalid;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_swn <= n_swn;
        r_err <= n_err;
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_prio <= s_axis_tdata[5:0];
            r_ev <= s_axis_tdata[13:6];
            r_cmask <= s_axis_tdata[21:14];
            r_tmo <= s_axis_tdata[37:22];
            r_wstat <= s_axis_tdata[45:38];
            r_blk <= s_axis_tdata[46];
        end
    end

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        n_cur = r_cur;
        n_run = r_run;
        n_present = r_present;
        n_free = r_free;
        n_ticks = r_ticks;
        n_sw = r_sw;
        n_res = r_res;
        n_swn = r_swn;
        n_err = r_err;
        n_idx = r_idx;
        n_ovalid = r_ovalid;
        t_we = 1'b0;
        t_waddr = r_cur;
        t_wdata = '0;
        t_raddr = r_cur;
        e_we = 1'b0;
        e_wdata = e_rdata;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            bpts_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = bpts_pkg::S_READ;
                end
            end
            bpts_pkg::S_READ: begin
                n_res = r_cur;
                n_swn = 1'b0;
                n_err = bpts_pkg::E_OK;
                n_idx = '0;
                if (r_kind == bpts_pkg::K_TICK) begin
                    n_ticks = r_ticks + 32'd1;
                    n_state = r_run ? bpts_pkg::S_TICK_RD : bpts_pkg::S_OUT;
                end else begin
                    n_state = bpts_pkg::S_EXEC;
                end
            end
            bpts_pkg::S_EXEC: begin
                n_state = bpts_pkg::S_OUT;
                case (r_kind)
                    bpts_pkg::K_CREATE: begin
                        n_res = r_prio;
                        if (r_present[r_prio]) begin
                            n_err = bpts_pkg::E_PRIO_USED;
                        end else if (r_free == '0) begin
                            n_err = bpts_pkg::E_NO_SLOT;
                        end else begin
                            n_free = r_free - 1'b1;
                            n_present[r_prio] = 1'b1;
                            n_ready[r_prio] = 1'b1;
                            t_we = 1'b1;
                            t_waddr = r_prio;
                            t_wdata = '0;
                        end
                    end
                    bpts_pkg::K_SCHED: begin
                        if (!r_blk) begin
                            n_res = low_r[5:0];
                            if (low_r[5:0] != r_cur) begin
                                n_swn = 1'b1;
                                n_sw = r_sw + 32'd1;
                                n_cur = low_r[5:0];
                            end
                        end
                    end
                    bpts_pkg::K_START: begin
                        if (!r_run) begin
                            n_res = low_r[5:0];
                            n_swn = (low_r[5:0] != r_cur);
                            n_cur = low_r[5:0];
                            n_run = 1'b1;
                        end
                    end
                    bpts_pkg::K_WAIT: begin
                        if (ev_ok) begin
                            t_we = 1'b1;
                            t_wdata = {r_ev, r_wstat, DELAY_BITS'(r_tmo)};
                            n_ready[r_cur] = 1'b0;
                            e_we = 1'b1;
                            e_wdata = e_rdata | (64'd1 << r_cur);
                        end
                    end
                    bpts_pkg::K_READY: begin
                        if (ev_ok) begin
                            if (!low_e[6]) begin
                                n_err = bpts_pkg::E_NO_WAITER;
                                n_res = '0;
                            end else begin
                                e_we = 1'b1;
                                e_wdata = e_rdata & ~(64'd1 << low_e[5:0]);
                                n_res = low_e[5:0];
                                n_state = bpts_pkg::S_TICK_WR;
                                t_raddr = low_e[5:0];
                            end
                        end
                    end
                    bpts_pkg::K_REMOVE: begin
                        if (ev_ok) begin
                            e_we = 1'b1;
                            e_wdata = e_rdata & ~(64'd1 << r_cur);
                            t_we = 1'b1;
                            t_wdata = {8'd0, 8'd0, d_rd};
                        end
                    end
                    bpts_pkg::K_CLEAR: begin
                        if (ev_ok) begin
                            e_we = 1'b1;
                            e_wdata = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bpts_pkg::S_TICK_RD: begin
                t_raddr = r_idx[5:0];
                n_state = bpts_pkg::S_TICK_WR;
            end
            bpts_pkg::S_TICK_WR: begin
                if (r_kind == bpts_pkg::K_READY) begin
                    t_we = 1'b1;
                    t_waddr = r_res;
                    t_wdata = {8'd0, st_new, {DELAY_BITS{1'b0}}};
                    if (st_new == 8'd0) begin
                        n_ready[r_res] = 1'b1;
                    end
                    n_state = bpts_pkg::S_OUT;
                end else begin
                    t_waddr = r_idx[5:0];
                    if (r_present[r_idx[5:0]] && r_idx[5:0] != bpts_pkg::IDLE_PRIO
                            && d_rd != '0) begin
                        t_we = 1'b1;
                        t_wdata = t_rdata;
                        t_wdata[DELAY_BITS-1:0] = d_dec;
                        if (d_dec == '0) begin
                            if (st_rd[bpts_pkg::SUSPEND_BIT]) begin
                                t_wdata[DELAY_BITS-1:0] = DELAY_BITS'(1);
                            end else begin
                                n_ready[r_idx[5:0]] = 1'b1;
                            end
                        end
                    end
                    n_idx = r_idx + 7'd1;
                    n_state = (r_idx == 7'd63) ? bpts_pkg::S_OUT : bpts_pkg::S_TICK_RD;
                end
            end
            bpts_pkg::S_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_state = bpts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpts_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/bpts_checker.sv
// Port-level checker for the bitmap priority task scheduler.
// Depends on bitmap_priority_task_scheduler_defines.svh; bound to the top level.
`default_nettype none
`include "bitmap_priority_task_scheduler_defines.svh"
module bpts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata
);
    `BPTS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    `BPTS_ASSERT(a_no_accept_busy, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "input taken while a result waits")
    `BPTS_ASSERT(a_switch_flag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[8:7] == 2'd0, "switch flagged with an error")
    `BPTS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
endmodule
bind bitmap_priority_task_scheduler bpts_checker u_bpts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> test/sched_checker.sv
// Scoreboard for the bitmap priority task scheduler: predicts each result beat
// from the accepted input beats and compares them. Depends on bpts_pkg.
`timescale 1ns / 1ps
module sched_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_in_user,
    input  wire logic [47:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [79:0] i_out_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_accepted
);
    logic [63:0] ready_map;
    logic [5:0]  cur_prio;
    logic        running;
    logic [63:0] present;
    logic [15:0] delay [64];
    logic [7:0]  status [64];
    logic [5:0]  free_slots;
    logic [63:0] wait_map [256];
    logic [31:0] ticks;
    logic [31:0] switches;
    logic [79:0] expected_q [$];

    function automatic logic [5:0] first_set(logic [63:0] map);
        for (int i = 0; i < 64; i++) begin
            if (map[i]) begin
                return 6'(i);
            end
        end
        return 6'd0;
    endfunction

    function automatic logic [79:0] schedule_step(logic [2:0] u, logic [47:0] d);
        bpts_pkg::t_kind kind;
        logic [5:0]  prio;
        logic [7:0]  ev;
        logic [7:0]  cmask;
        logic [15:0] tmo;
        logic [7:0]  wstat;
        logic        blocked;
        logic [5:0]  res;
        logic [5:0]  cur;
        logic        sw;
        bpts_pkg::t_err err;
        logic [5:0]  p;
        kind = bpts_pkg::t_kind'(u);
        prio = d[5:0];
        ev = d[13:6];
        cmask = d[21:14];
        tmo = d[37:22];
        wstat = d[45:38];
        blocked = d[46];
        cur = cur_prio;
        res = cur_prio;
        sw = 1'b0;
        err = bpts_pkg::E_OK;
        case (kind)
            bpts_pkg::K_TICK: begin
                ticks++;
                if (running) begin
                    for (int i = 0; i < 63; i++) begin
                        if (present[i] && delay[i] != 0) begin
                            delay[i]--;
                            if (delay[i] == 0) begin
                                if (status[i][bpts_pkg::SUSPEND_BIT]) begin
                                    delay[i] = 16'd1;
                                end else begin
                                    ready_map[i] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            bpts_pkg::K_CREATE: begin
                res = prio;
                if (present[prio]) begin
                    err = bpts_pkg::E_PRIO_USED;
                end else if (free_slots == 0) begin
                    err = bpts_pkg::E_NO_SLOT;
                end else begin
                    free_slots--;
                    present[prio] = 1'b1;
                    status[prio] = 8'd0;
                    delay[prio] = 16'd0;
                    ready_map[prio] = 1'b1;
                end
            end
            bpts_pkg::K_SCHED: begin
                if (!blocked) begin
                    res = first_set(ready_map);
                    if (res != cur) begin
                        sw = 1'b1;
                        switches++;
                        cur_prio = res;
                    end
                end
            end
            bpts_pkg::K_START: begin
                if (!running) begin
                    res = first_set(ready_map);
                    sw = res != cur;
                    cur_prio = res;
                    running = 1'b1;
                end
            end
            bpts_pkg::K_WAIT: begin
                delay[cur] = tmo;
                status[cur] = wstat;
                ready_map[cur] = 1'b0;
                wait_map[ev][cur] = 1'b1;
            end
            bpts_pkg::K_READY: begin
                if (wait_map[ev] == 0) begin
                    err = bpts_pkg::E_NO_WAITER;
                    res = 6'd0;
                end else begin
                    p = first_set(wait_map[ev]);
                    wait_map[ev][p] = 1'b0;
                    delay[p] = 16'd0;
                    status[p] = status[p] & ~cmask;
                    if (status[p] == 0) begin
                        ready_map[p] = 1'b1;
                    end
                    res = p;
                end
            end
            bpts_pkg::K_REMOVE: begin
                wait_map[ev][cur] = 1'b0;
                status[cur] = 8'd0;
            end
            default: begin
                wait_map[ev] = 64'd0;
            end
        endcase
        return {7'd0, ticks, switches, err, sw, res};
    endfunction

    always @(posedge i_clk) begin
        logic [79:0] exp_beat;
        if (!i_rst_n) begin
            ready_map = '0;
            cur_prio = '0;
            running = 1'b0;
            present = '0;
            free_slots = 6'd32;
            ticks = '0;
            switches = '0;
            for (int i = 0; i < 256; i++) begin
                wait_map[i] = '0;
            end
            for (int i = 0; i < 64; i++) begin
                delay[i] = '0;
                status[i] = '0;
            end
            expected_q.delete();
            o_errors <= 0;
            o_accepted <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(schedule_step(i_in_user, i_in_data));
                o_accepted <= o_accepted + 1;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_beat = expected_q.pop_front();
                    if (exp_beat[5:0] != i_out_data[5:0] || exp_beat[6] != i_out_data[6]
                        || exp_beat[8:7] != i_out_data[8:7]
                        || exp_beat[40:9] != i_out_data[40:9]
                        || exp_beat[72:41] != i_out_data[72:41]) begin
                        $display("%0t: mismatch expected prio %0d sw %0d err %0d swc %0d tick %0d",
                                 $time, exp_beat[5:0], exp_beat[6], exp_beat[8:7],
                                 exp_beat[40:9], exp_beat[72:41]);
                        $display("%0t:          actual prio %0d sw %0d err %0d swc %0d tick %0d",
                                 $time, i_out_data[5:0], i_out_data[6], i_out_data[8:7],
                                 i_out_data[40:9], i_out_data[72:41]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end
endmodule

>>> test/testbench.sv
// Top of the scheduler testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on bpts_pkg, sched_checker and bitmap_priority_task_scheduler.
`timescale 1ns / 1ps
module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          accepted;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          ev_ready [256];

    always #1 i_clk = ~i_clk;

    bitmap_priority_task_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    sched_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_user(s_axis_tuser), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_accepted(accepted)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(5, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send(bpts_pkg::t_kind kind, logic [5:0] prio, logic [7:0] ev,
                        logic [7:0] cmask, logic [15:0] tmo, logic [7:0] wstat,
                        logic blocked, int gap);
        int start_count;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (kind == bpts_pkg::K_CLEAR) begin
            ev_ready[ev] = 1'b1;
        end
        start_count = accepted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, blocked, wstat, tmo, cmask, ev, prio};
        do begin
            @(negedge i_clk);
        end while (accepted == start_count);
    endtask

    task automatic send_random(bit calm);
        bpts_pkg::t_kind kind;
        logic [7:0]  ev;
        logic [15:0] tmo;
        logic [7:0]  wstat;
        int          pick;
        int          gap;
        pick = $urandom_range(0, 99);
        kind = pick < 20 ? bpts_pkg::K_TICK : pick < 30 ? bpts_pkg::K_CREATE :
               pick < 50 ? bpts_pkg::K_SCHED : pick < 55 ? bpts_pkg::K_START :
               pick < 70 ? bpts_pkg::K_WAIT : pick < 85 ? bpts_pkg::K_READY :
               pick < 93 ? bpts_pkg::K_REMOVE : bpts_pkg::K_CLEAR;
        ev = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        if (!ev_ready[ev]) begin
            kind = bpts_pkg::K_CLEAR;
        end
        tmo = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        pick = $urandom_range(0, 9);
        wstat = pick < 5 ? 8'd0 : pick < 8 ? 8'h08 : 8'($urandom);
        gap = calm ? 0 : ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(5, 40);
        send(kind, 6'($urandom), ev, 8'($urandom), tmo, wstat,
             $urandom_range(0, 9) == 0, gap);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send(bpts_pkg::K_CLEAR, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_CLEAR, 6'd63, 8'd255, 8'hff, 16'hffff, 8'hff, 1'b1, 1);
        for (int e = 1; e < 8; e++) begin
            send(bpts_pkg::K_CLEAR, 6'd0, 8'(e), 8'd0, 16'd0, 8'd0, 1'b0, 0);
        end
        send(bpts_pkg::K_SCHED, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_CREATE, 6'd63, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_CREATE, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 2);
        send(bpts_pkg::K_CREATE, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_CREATE, 6'd5, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_TICK, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_SCHED, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b1, 0);
        send(bpts_pkg::K_START, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_START, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_WAIT, 6'd0, 8'd255, 8'd0, 16'hffff, 8'hff, 1'b0, 0);
        send(bpts_pkg::K_SCHED, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_WAIT, 6'd0, 8'd0, 8'd0, 16'd2, 8'h08, 1'b0, 3);
        repeat (3) send(bpts_pkg::K_TICK, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_READY, 6'd0, 8'd255, 8'hff, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_READY, 6'd0, 8'd1, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_REMOVE, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_READY, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        send(bpts_pkg::K_SCHED, 6'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 0);
        for (int n = 0; n < 2000; n++) begin
            if (n == 1000) begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            send_random((n / 100) % 4 == 3);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
